FILE: hdl/fcdma_pkg.sv
`timescale 1ns / 1ps
package fcdma_pkg;

  localparam int ADDR_W = 27;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_PIECE   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_SPECIAL = 2'd3;

  localparam logic [1:0] MODE_INC    = 2'd0;
  localparam logic [1:0] MODE_DEC    = 2'd1;
  localparam logic [1:0] MODE_FIXED  = 2'd2;
  localparam logic [1:0] MODE_RELOAD = 2'd3;

  localparam logic [14:0] FULL_COUNT = 15'd16384;
  localparam logic [14:0] FIFO_UNITS = 15'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  channel;
    logic [26:0] source_address;
    logic [26:0] dest_address;
    logic [13:0] unit_count;
    logic [15:0] control_word;
    logic        dest_is_io;
    logic [1:0]  trigger_event;
  } req_t;

  typedef struct packed {
    logic [26:0] copy_source;
    logic [26:0] copy_dest;
    logic        wide_unit;
    logic [1:0]  active_channel;
    logic [6:0]  piece_ticks;
    logic        irq_request;
    logic        enable_cleared;
    logic        last_of_piece;
  } rsp_t;

endpackage

FILE: hdl/fcdma_queue.sv
`timescale 1ns / 1ps
module fcdma_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  fcdma_pkg::req_t   in_data,
  output logic              out_valid,
  input  logic              out_take,
  output fcdma_pkg::req_t   out_data
);

  fcdma_pkg::req_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            push;
  logic            pop;

  assign in_stall  = (fill == 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push = in_valid && !in_stall;
  assign pop  = out_valid && out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

FILE: hdl/fcdma_engine.sv
`timescale 1ns / 1ps
module fcdma_engine #(
  parameter int NUM_CHANNELS = 4,
  parameter int PIECE_LIMIT  = 32,
  parameter int ADDR_BITS    = 27
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_take,
  input  fcdma_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output fcdma_pkg::rsp_t  rsp
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PW = $clog2(PIECE_LIMIT + 1);
  localparam logic [ADDR_BITS-1:0] AMASK = '1;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_t;

  logic [NUM_CHANNELS-1:0] running, armed, repeat_en, wide, reload_dest, irq_en;
  logic [1:0]              start_ev    [NUM_CHANNELS];
  logic [14:0]             remaining   [NUM_CHANNELS];
  logic [ADDR_BITS-1:0]    cur_src     [NUM_CHANNELS];
  logic [ADDR_BITS-1:0]    cur_dst     [NUM_CHANNELS];
  logic [3:0]              src_step    [NUM_CHANNELS];
  logic [3:0]              dst_step    [NUM_CHANNELS];
  logic [ADDR_BITS-1:0]    shadow_dst  [NUM_CHANNELS];
  logic [13:0]             shadow_cnt  [NUM_CHANNELS];

  state_t          state;
  logic [CW-1:0]   act;
  logic [PW-1:0]   left;
  logic [PW-1:0]   total;
  logic            done_fin;

  // Lowest running channel.
  logic          found;
  logic [CW-1:0] pick;
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (running[i]) begin
        found = 1'b1;
        pick  = CW'(i);
      end
    end
  end

  logic [1:0] op_code;
  assign op_code = req.operation;
  assign req_take = req_valid && (state == ST_IDLE) && !(rsp_valid && rsp_stall);

  logic [CW-1:0] wr_ch;
  assign wr_ch = CW'(req.channel);

  // Control word decode.
  logic [15:0] cw;
  logic [1:0]  start, dmode, smode;
  logic        rep_bit, fifo, wide_d, reload_d;
  logic [3:0]  ds, ss;
  logic [14:0] cnt_d;
  always_comb begin
    cw      = req.control_word;
    start   = cw[13:12];
    dmode   = cw[6:5];
    smode   = cw[8:7];
    rep_bit = cw[9] && (start != 2'd0);
    fifo    = req.dest_is_io && cw[9] && start == fcdma_pkg::EV_SPECIAL
              && (req.channel == 2'd1 || req.channel == 2'd2);
    wide_d   = fifo ? 1'b1 : cw[10];
    reload_d = !fifo && dmode == fcdma_pkg::MODE_RELOAD;
    cnt_d    = fifo ? fcdma_pkg::FIFO_UNITS :
               (req.unit_count == 14'd0 ? fcdma_pkg::FULL_COUNT : {1'b0, req.unit_count});
    unique case (dmode)
      fcdma_pkg::MODE_INC, fcdma_pkg::MODE_RELOAD: ds = wide_d ? 4'd4 : 4'd2;
      fcdma_pkg::MODE_DEC: ds = wide_d ? 4'hC : 4'hE;
      default: ds = 4'd0;
    endcase
    if (fifo) begin
      ds = 4'd0;
    end
    unique case (smode)
      fcdma_pkg::MODE_INC: ss = wide_d ? 4'd4 : 4'd2;
      fcdma_pkg::MODE_DEC: ss = wide_d ? 4'hC : 4'hE;
      default: ss = 4'd0;
    endcase
  end

  logic [14:0] rem_sel;
  logic [14:0] take_cnt;
  assign rem_sel  = remaining[pick];
  assign take_cnt = (rem_sel > 15'(PIECE_LIMIT)) ? 15'(PIECE_LIMIT) : rem_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      running   <= '0;
      armed     <= '0;
      repeat_en <= '0;
      wide      <= '0;
      reload_dest <= '0;
      irq_en    <= '0;
      act <= '0;
      left <= '0;
      total <= '0;
      done_fin <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_ev[i]   <= '0;
        remaining[i]  <= '0;
        cur_src[i]    <= '0;
        cur_dst[i]    <= '0;
        src_step[i]   <= '0;
        dst_step[i]   <= '0;
        shadow_dst[i] <= '0;
        shadow_cnt[i] <= '0;
      end
    end else begin
      if (rsp_valid && !rsp_stall && state != ST_COPY) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            unique case (op_code)
              fcdma_pkg::OP_WRITE: begin
                if (32'(req.channel) < NUM_CHANNELS) begin
                  shadow_dst[wr_ch] <= ADDR_BITS'(req.dest_address);
                  shadow_cnt[wr_ch] <= req.unit_count;
                  irq_en[wr_ch]     <= cw[14];
                  if (!cw[15]) begin
                    running[wr_ch] <= 1'b0;
                    armed[wr_ch]   <= 1'b0;
                  end else begin
                    cur_src[wr_ch]     <= ADDR_BITS'(req.source_address);
                    cur_dst[wr_ch]     <= ADDR_BITS'(req.dest_address);
                    repeat_en[wr_ch]   <= rep_bit;
                    running[wr_ch]     <= (start == fcdma_pkg::EV_NONE);
                    start_ev[wr_ch]    <= start;
                    reload_dest[wr_ch] <= reload_d;
                    remaining[wr_ch]   <= cnt_d;
                    wide[wr_ch]        <= wide_d;
                    dst_step[wr_ch]    <= ds;
                    src_step[wr_ch]    <= ss;
                    armed[wr_ch]       <= 1'b1;
                  end
                end
              end
              fcdma_pkg::OP_TRIGGER: begin
                if (req.trigger_event != fcdma_pkg::EV_NONE) begin
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (armed[i] && !running[i] && start_ev[i] == req.trigger_event) begin
                      running[i] <= 1'b1;
                      if (req.trigger_event == fcdma_pkg::EV_SPECIAL) begin
                        remaining[i] <= fcdma_pkg::FIFO_UNITS;
                      end else begin
                        remaining[i] <= (shadow_cnt[i] == 14'd0) ? fcdma_pkg::FULL_COUNT
                                        : {1'b0, shadow_cnt[i]};
                        if (reload_dest[i]) begin
                          cur_dst[i] <= shadow_dst[i];
                        end
                      end
                    end
                  end
                end
              end
              fcdma_pkg::OP_PIECE: begin
                if (found) begin
                  if (rem_sel == 15'd0) begin
                    running[pick] <= 1'b0;
                  end else begin
                    remaining[pick] <= rem_sel - take_cnt;
                    act      <= pick;
                    left     <= PW'(take_cnt);
                    total    <= PW'(take_cnt);
                    done_fin <= (rem_sel == take_cnt);
                    state    <= ST_COPY;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_COPY: begin
          if (!(rsp_valid && rsp_stall)) begin
            rsp_valid <= 1'b1;
            rsp.copy_source    <= fcdma_pkg::ADDR_W'(cur_src[act]);
            rsp.copy_dest      <= fcdma_pkg::ADDR_W'(cur_dst[act]);
            rsp.wide_unit      <= wide[act];
            rsp.active_channel <= 2'(act);
            rsp.last_of_piece  <= (left == PW'(1));
            rsp.piece_ticks    <= (left == PW'(1)) ? 7'({total, 1'b0}) : 7'd0;
            rsp.irq_request    <= (left == PW'(1)) && done_fin && irq_en[act];
            rsp.enable_cleared <= (left == PW'(1)) && done_fin && !repeat_en[act];
            cur_src[act] <= (cur_src[act] + {{(ADDR_BITS-4){src_step[act][3]}}, src_step[act]})
                            & AMASK;
            cur_dst[act] <= (cur_dst[act] + {{(ADDR_BITS-4){dst_step[act][3]}}, dst_step[act]})
                            & AMASK;
            left <= left - PW'(1);
            if (left == PW'(1)) begin
              if (done_fin) begin
                running[act] <= 1'b0;
                if (!repeat_en[act]) begin
                  armed[act] <= 1'b0;
                end
              end
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/four_channel_dma_controller.sv
`timescale 1ns / 1ps
// Control writes and trigger events are handled after the queue by the idle engine.
// A piece tick of n units gives n copy commands, one per cycle unless the output
// stalls; n is at most PIECE_LIMIT. The channel is picked in the idle state, and each
// command is registered in the copy state. A two-entry request queue lets new requests
// enter while the engine copies. Synchronous reset clears all channel state and the queue.
module four_channel_dma_controller #(
  parameter int NUM_CHANNELS = 4,
  parameter int PIECE_LIMIT  = 32,
  parameter int ADDR_BITS    = 27
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  fcdma_pkg::req_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fcdma_pkg::rsp_t  out_data
);

  logic            q_valid;
  logic            q_take;
  fcdma_pkg::req_t q_data;

  fcdma_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(q_valid), .out_take(q_take), .out_data(q_data)
  );

  fcdma_engine #(
    .NUM_CHANNELS(NUM_CHANNELS), .PIECE_LIMIT(PIECE_LIMIT), .ADDR_BITS(ADDR_BITS)
  ) u_engine (
    .clk(clk), .rst(rst),
    .req_valid(q_valid), .req_take(q_take), .req(q_data),
    .rsp_valid(out_valid), .rsp_stall(out_stall), .rsp(out_data)
  );

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_quiet_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_of_piece |-> out_data.piece_ticks == 7'd0)
    else $error("ticks on non-last command");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule
